@@ design/swfd_pkg.sv @@
`timescale 1ns / 1ps

package swfd_pkg;

  // default geometry of the frame
  localparam int FRAME_SIZE_DEF = 56;
  localparam int SYNC_BITS_DEF  = 32;
  localparam int CRC_FIRST_DEF  = 5;
  localparam int CRC_COUNT_DEF  = 49;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED  = 2'd3;

  // configuration reset values
  localparam logic        INVERT_RST    = 1'b0;
  localparam logic [31:0] SYNC_WORD_RST = 32'h5555_552D;
  localparam logic [15:0] CRC_POLY_RST  = 16'h8005;
  localparam logic [15:0] CRC_SEED_RST  = 16'h0000;

  // internal byte position (frames up to 256 bytes), output position, compare width
  localparam int IDX_W     = 8;
  localparam int OUT_IDX_W = 6;
  localparam int CMP_W     = 9;
  // count of sync bytes still to send (up to four)
  localparam int SLEFT_W   = 3;

  // byte events from the bit stage to the byte stage
  typedef struct packed {
    logic             sync;
    logic             data;
    logic [7:0]       value;
    logic [IDX_W-1:0] idx;
  } swfd_evt_t;

  // one byte through the crc-16 register, msb first, no reflection
  function automatic logic [15:0] crc16_byte(input logic [15:0] rem,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
    logic [15:0] r;
    r = rem ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ poly) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ design/sync_word_frame_deframer_crc16.sv @@
`timescale 1ns / 1ps

// Sync-word deframer with CRC-16 check. Each input transfer carries one
// demodulated bit or a gap marker; one is taken per clock cycle while in_ready
// is high. While hunting, the block compares the last SYNC_BITS bits against
// the sync word (no gap allowed among them); on a match it sends the whole sync
// bytes, then packs every further bit MSB first and sends each byte as it
// completes, up to FRAME_SIZE per frame, with its position in byte_index. The
// CRC-16 over bytes CRC_FIRST .. CRC_FIRST+CRC_COUNT-1 is checked against
// the two bytes that follow, and the result shows as crc_ok on the byte marked
// last. Each output transfer moves one byte; the sync bytes leave one per cycle
// while out_ready is high, from a copy of the sync word, while input keeps
// flowing. A completed data byte waits in a holding slot for the output
// register. in_ready falls only while a completed data byte is held behind a
// stalled output register or sync bytes not yet sent, so a stall on the output
// side reaches the input one byte later. The CRC register takes one byte per
// cycle while bytes enter the output register. Write registers over the cfg_
// port only while the block is idle; the block itself enforces none of this.
module sync_word_frame_deframer_crc16 #(
  parameter int FRAME_SIZE  = swfd_pkg::FRAME_SIZE_DEF,
  parameter int SYNC_BITS   = swfd_pkg::SYNC_BITS_DEF,
  parameter int CRC_FIRST   = swfd_pkg::CRC_FIRST_DEF,
  parameter int CRC_COUNT   = swfd_pkg::CRC_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic                                in_bit_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte_value,
  output logic [swfd_pkg::OUT_IDX_W-1:0]      out_byte_index,
  output logic                                out_last,
  output logic                                out_crc_ok,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);

  logic        invert_r;
  logic [31:0] sync_word_r;
  logic [15:0] crc_poly_r;
  logic [15:0] crc_seed_r;

  logic                in_fire;
  logic                can_accept;
  swfd_pkg::swfd_evt_t evt;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r    <= swfd_pkg::INVERT_RST;
      sync_word_r <= swfd_pkg::SYNC_WORD_RST;
      crc_poly_r  <= swfd_pkg::CRC_POLY_RST;
      crc_seed_r  <= swfd_pkg::CRC_SEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swfd_pkg::REG_INVERT:    invert_r    <= cfg_data[0];
        swfd_pkg::REG_SYNC_WORD: sync_word_r <= cfg_data;
        swfd_pkg::REG_CRC_POLY:  crc_poly_r  <= cfg_data[15:0];
        swfd_pkg::REG_CRC_SEED:  crc_seed_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input transfer
  assign in_ready = can_accept;
  assign in_fire  = in_valid && in_ready;

  swfd_bit_stage #(
    .FRAME_SIZE (FRAME_SIZE),
    .SYNC_BITS  (SYNC_BITS)
  ) u_bit (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .action    (in_action),
    .bit_value (in_bit_value),
    .invert    (invert_r),
    .sync_word (sync_word_r),
    .evt       (evt)
  );

  swfd_byte_stage #(
    .FRAME_SIZE  (FRAME_SIZE),
    .SYNC_BITS   (SYNC_BITS),
    .CRC_FIRST   (CRC_FIRST),
    .CRC_COUNT   (CRC_COUNT)
  ) u_byte (
    .clk            (clk),
    .rst_n          (rst_n),
    .evt            (evt),
    .sync_word      (sync_word_r),
    .crc_poly       (crc_poly_r),
    .crc_seed       (crc_seed_r),
    .can_accept     (can_accept),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_value (out_byte_value),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_crc_ok     (out_crc_ok)
  );

endmodule

@@ design/swfd_bit_stage.sv @@
`timescale 1ns / 1ps

module swfd_bit_stage #(
  parameter int FRAME_SIZE = swfd_pkg::FRAME_SIZE_DEF,
  parameter int SYNC_BITS  = swfd_pkg::SYNC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                action,
  input  logic                bit_value,
  input  logic                invert,
  input  logic [31:0]         sync_word,
  output swfd_pkg::swfd_evt_t evt
);

  localparam int CW  = $clog2(FRAME_SIZE * 8 + 1);
  localparam int CLW = $clog2(SYNC_BITS + 1);
  localparam logic [CLW-1:0] SYNC_C  = CLW'(SYNC_BITS);
  localparam logic [CW-1:0]  FRAME_C = CW'(FRAME_SIZE * 8);
  localparam logic [CW-1:0]  SYNC_CNT = CW'(SYNC_BITS);

  logic [SYNC_BITS-1:0] hist_r;
  logic [CLW-1:0]       clean_r;
  logic                 in_frame_r;
  logic [CW-1:0]        cnt_r;
  logic [7:0]           acc_r;

  logic                 b;
  logic [SYNC_BITS-1:0] hist_nxt;
  logic [CLW-1:0]       clean_nxt;
  logic [CW-1:0]        cnt_nxt;
  logic [7:0]           acc_nxt;
  logic                 sync_hit;
  logic                 byte_done;
  logic                 frame_end;
  logic                 data_bit;

  // bit after optional inversion, history and clean run length
  assign b         = bit_value ^ invert;
  assign data_bit  = fire && !action;
  assign hist_nxt  = {hist_r[SYNC_BITS-2:0], b};
  assign clean_nxt = (clean_r == SYNC_C) ? clean_r : clean_r + CLW'(1);

  // sync search while hunting
  assign sync_hit = !in_frame_r && (clean_nxt == SYNC_C) &&
                    (hist_nxt == sync_word[SYNC_BITS-1:0]);

  // byte packing inside a frame
  assign cnt_nxt   = cnt_r + CW'(1);
  assign acc_nxt   = {acc_r[6:0], b};
  assign byte_done = (cnt_nxt[2:0] == 3'd0);
  assign frame_end = (cnt_nxt == FRAME_C);

  always_comb begin
    evt       = '0;
    evt.sync  = data_bit && sync_hit;
    evt.data  = data_bit && in_frame_r && byte_done;
    evt.value = acc_nxt;
    evt.idx   = swfd_pkg::IDX_W'(cnt_nxt[CW-1:3] - (CW-3)'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r     <= '0;
      clean_r    <= '0;
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      acc_r      <= '0;
    end else if (fire) begin
      if (action) begin
        // gap marker only breaks the clean run
        clean_r <= '0;
      end else begin
        hist_r  <= hist_nxt;
        clean_r <= clean_nxt;
        if (in_frame_r) begin
          if (frame_end) begin
            in_frame_r <= 1'b0;
            cnt_r      <= '0;
            acc_r      <= '0;
          end else begin
            cnt_r <= cnt_nxt;
            acc_r <= acc_nxt;
          end
        end else if (sync_hit) begin
          // sync bits count as frame bits, leftover bits start the next byte
          in_frame_r <= 1'b1;
          cnt_r      <= SYNC_CNT;
          acc_r      <= sync_word[7:0];
        end
      end
    end
  end

endmodule

@@ design/swfd_byte_stage.sv @@
`timescale 1ns / 1ps

module swfd_byte_stage #(
  parameter int FRAME_SIZE  = swfd_pkg::FRAME_SIZE_DEF,
  parameter int SYNC_BITS   = swfd_pkg::SYNC_BITS_DEF,
  parameter int CRC_FIRST   = swfd_pkg::CRC_FIRST_DEF,
  parameter int CRC_COUNT   = swfd_pkg::CRC_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swfd_pkg::swfd_evt_t                 evt,
  input  logic [31:0]                         sync_word,
  input  logic [15:0]                         crc_poly,
  input  logic [15:0]                         crc_seed,
  output logic                                can_accept,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte_value,
  output logic [swfd_pkg::OUT_IDX_W-1:0]      out_byte_index,
  output logic                                out_last,
  output logic                                out_crc_ok
);

  localparam int NSB = SYNC_BITS / 8;
  localparam logic [swfd_pkg::SLEFT_W-1:0] NSB_C = swfd_pkg::SLEFT_W'(NSB);
  localparam logic [swfd_pkg::CMP_W-1:0] CRC_LO  = swfd_pkg::CMP_W'(CRC_FIRST);
  localparam logic [swfd_pkg::CMP_W-1:0] CRC_HI  = swfd_pkg::CMP_W'(CRC_FIRST + CRC_COUNT);
  localparam logic [swfd_pkg::CMP_W-1:0] CRC_HI1 = swfd_pkg::CMP_W'(CRC_FIRST + CRC_COUNT + 1);
  localparam logic [swfd_pkg::CMP_W-1:0] LAST_C  = swfd_pkg::CMP_W'(FRAME_SIZE - 1);

  // sync byte source and one-entry holding slot for data bytes
  logic [SYNC_BITS-1:0]              snap_r;
  logic [swfd_pkg::SLEFT_W-1:0]      sleft_r;
  logic                              pend_valid_r;
  logic [7:0]                        pend_value_r;
  logic [swfd_pkg::IDX_W-1:0]        pend_idx_r;

  // crc state
  logic [15:0] crc_r;
  logic [7:0]  hb_r;
  logic        match_r;

  // output register
  logic                              out_valid_r;
  logic [7:0]                        out_value_r;
  logic [swfd_pkg::OUT_IDX_W-1:0]    out_idx_r;
  logic                              out_last_r;
  logic                              out_ok_r;

  logic                              sel_sync;
  logic                              sel_pend;
  logic                              load_out;
  logic                              take;
  logic                              pend_take;
  logic [7:0]                        cur_value;
  logic [swfd_pkg::IDX_W-1:0]        cur_idx;
  logic [swfd_pkg::CMP_W-1:0]        cur_idx_w;
  logic [15:0]                       rem_base;
  logic                              match_base;
  logic [15:0]                       crc_nxt;
  logic                              match_nxt;
  logic                              cur_last;

  // sync bytes go first, then the held data byte
  assign sel_sync   = (sleft_r != '0);
  assign sel_pend   = !sel_sync && pend_valid_r;
  assign load_out   = !out_valid_r || out_ready;
  assign take       = load_out && (sel_sync || sel_pend);
  assign pend_take  = take && sel_pend;
  assign can_accept = !pend_valid_r || pend_take;

  assign cur_value = sel_sync ? snap_r[SYNC_BITS-1 -: 8] : pend_value_r;
  assign cur_idx   = sel_sync ? swfd_pkg::IDX_W'(NSB_C - sleft_r) : pend_idx_r;
  assign cur_idx_w = swfd_pkg::CMP_W'(cur_idx);

  // crc over the covered bytes, restarted by byte zero of each frame
  always_comb begin
    rem_base   = (cur_idx == '0) ? crc_seed : crc_r;
    match_base = (cur_idx == '0) ? 1'b0 : match_r;
    crc_nxt    = rem_base;
    match_nxt  = match_base;
    if (cur_idx_w >= CRC_LO && cur_idx_w < CRC_HI) begin
      crc_nxt = swfd_pkg::crc16_byte(rem_base, cur_value, crc_poly);
    end
    if (cur_idx_w == CRC_HI1) begin
      match_nxt = (rem_base == {hb_r, cur_value});
    end
  end

  assign cur_last = (cur_idx_w == LAST_C);

  // sync byte source and holding slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sleft_r      <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (evt.sync) begin
        sleft_r <= NSB_C;
      end else if (take && sel_sync) begin
        sleft_r <= sleft_r - swfd_pkg::SLEFT_W'(1);
      end
      if (evt.data) begin
        pend_valid_r <= 1'b1;
      end else if (pend_take) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.sync) begin
      snap_r <= sync_word[SYNC_BITS-1:0];
    end else if (take && sel_sync) begin
      snap_r <= snap_r << 8;
    end
    if (evt.data) begin
      pend_value_r <= evt.value;
      pend_idx_r   <= evt.idx;
    end
  end

  // crc registers follow every byte that leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= swfd_pkg::CRC_SEED_RST;
      match_r <= 1'b0;
    end else if (take) begin
      crc_r   <= crc_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cur_idx_w == CRC_HI) begin
      hb_r <= cur_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_value_r <= cur_value;
      out_idx_r   <= swfd_pkg::OUT_IDX_W'(cur_idx);
      out_last_r  <= cur_last;
      out_ok_r    <= cur_last && match_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_value = out_value_r;
  assign out_byte_index = out_idx_r;
  assign out_last       = out_last_r;
  assign out_crc_ok     = out_ok_r;

endmodule

@@ tb/tb_sync_word_frame_deframer_crc16.sv @@
`timescale 1ns / 1ps

module tb_sync_word_frame_deframer_crc16;

  // frame geometry as built into the block
  localparam int FRM_SIZE  = swfd_pkg::FRAME_SIZE_DEF;
  localparam int SYNC_LEN  = swfd_pkg::SYNC_BITS_DEF;
  localparam int CRC_START = swfd_pkg::CRC_FIRST_DEF;
  localparam int CRC_LEN   = swfd_pkg::CRC_COUNT_DEF;
  localparam int CRC_AT    = CRC_START + CRC_LEN;
  // payload bytes sent in each idling phase
  localparam int PHASE_BYTES = (FRM_SIZE - 4) / 4;

  // input item kinds
  localparam logic ACT_BIT = 1'b0;
  localparam logic ACT_GAP = 1'b1;

  // one frame byte as it leaves the block
  typedef struct packed {
    logic [7:0]                     value;
    logic [swfd_pkg::OUT_IDX_W-1:0] pos;
    logic                           last;
    logic                           crc_ok;
  } frame_byte_t;

  // one run of identical-kind items; nres typed results are taken in order
  typedef struct {
    logic        act;
    logic [31:0] pattern;
    int          nbits;
    int          nres;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_action = 1'b0;
  logic                           in_bit_value = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [7:0]                     out_byte_value;
  logic [swfd_pkg::OUT_IDX_W-1:0] out_byte_index;
  logic                           out_last;
  logic                           out_crc_ok;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [swfd_pkg::CFG_IDX_W-1:0] cfg_index = swfd_pkg::REG_INVERT;
  logic [31:0]                    cfg_data = 32'd0;

  // register shadows
  logic        cfg_inv  = swfd_pkg::INVERT_RST;
  logic [31:0] cfg_sync = swfd_pkg::SYNC_WORD_RST;
  logic [15:0] cfg_poly = swfd_pkg::CRC_POLY_RST;
  logic [15:0] cfg_seed = swfd_pkg::CRC_SEED_RST;

  // deframer state as predicted
  logic [31:0] hist = 32'd0;
  int          clean_cnt = 0;
  bit          framing = 1'b0;
  int          fbits = 0;
  logic [7:0]  acc = 8'd0;
  logic [15:0] crc_rem = swfd_pkg::CRC_SEED_RST;
  logic [7:0]  crc_hi = 8'd0;
  bit          crc_match = 1'b0;

  frame_byte_t pred_out[$];
  frame_byte_t expected_bytes[$];
  frame_byte_t typed_bytes[$];
  stim_row_t   directed[3];
  logic [7:0]  body [FRM_SIZE];

  bit          use_typed = 1'b0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          errors = 0;

  sync_word_frame_deframer_crc16 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_bit_value   (in_bit_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte_value (out_byte_value),
    .out_byte_index (out_byte_index),
    .out_last       (out_last),
    .out_crc_ok     (out_crc_ok),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // bit-serial crc-16, msb first
  function automatic logic [15:0] crc_shift_byte(input logic [15:0] r, input logic [7:0] d,
                                                  input logic [15:0] poly);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r = {r[14:0], 1'b0} ^ (fb ? poly : 16'h0000);
    end
    return r;
  endfunction

  // completed byte: crc bookkeeping and the result it produces
  function automatic void emit_frame_byte(input logic [7:0] v, input int idx);
    frame_byte_t fb;
    if (idx >= CRC_START && idx < CRC_AT) crc_rem = crc_shift_byte(crc_rem, v, cfg_poly);
    if (idx == CRC_AT) crc_hi = v;
    if (idx == CRC_AT + 1) crc_match = (crc_rem == {crc_hi, v});
    fb.value  = v;
    fb.pos    = idx[swfd_pkg::OUT_IDX_W-1:0];
    fb.last   = (idx == FRM_SIZE - 1);
    fb.crc_ok = fb.last && crc_match;
    pred_out.push_back(fb);
  endfunction

  function automatic void pack_frame_bit(input logic b);
    acc = {acc[6:0], b};
    fbits++;
    if (fbits % 8 == 0) emit_frame_byte(acc, fbits / 8 - 1);
    if (fbits >= FRM_SIZE * 8) begin
      framing = 1'b0;
      fbits = 0;
      acc = 8'd0;
    end
  endfunction

  // one accepted input item through the deframer
  function automatic void predict_deframe(input logic act, input logic bv);
    logic b;
    if (act == ACT_GAP) begin
      clean_cnt = 0;
      return;
    end
    b = bv ^ cfg_inv;
    hist = {hist[30:0], b};
    if (clean_cnt < SYNC_LEN) clean_cnt++;
    if (framing) begin
      pack_frame_bit(b);
    end else if (clean_cnt >= SYNC_LEN && hist == cfg_sync) begin
      framing = 1'b1;
      fbits = 0;
      acc = 8'd0;
      crc_rem = cfg_seed;
      crc_match = 1'b0;
      for (int k = SYNC_LEN - 1; k >= 0; k--) pack_frame_bit(cfg_sync[k]);
    end
  endfunction

  // offer one item, entered and left just after a falling edge
  task automatic send_item(input logic act, input logic bv);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_bit_value <= bv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_deframe(act, bv);
    if (!use_typed)
      while (pred_out.size() > 0) expected_bytes.push_back(pred_out.pop_front());
    pred_out.delete();
    @(negedge clk);
  endtask

  // sync word with a gap cut into it, so it must not lock
  task automatic send_broken_sync();
    int cut;
    cut = $urandom_range(SYNC_LEN - 2, 1);
    for (int k = SYNC_LEN - 1; k >= 0; k--) begin
      if (k == cut) send_item(ACT_GAP, 1'($urandom_range(1)));
      send_item(ACT_BIT, cfg_sync[k] ^ cfg_inv);
    end
  endtask

  // frame contents with random payload, crc right or deliberately spoilt
  task automatic make_frame(input bit good_crc);
    logic [15:0] r;
    int          flip;
    for (int i = 0; i < FRM_SIZE; i++) body[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) body[i] = cfg_sync[31 - 8 * i -: 8];
    r = cfg_seed;
    for (int i = CRC_START; i < CRC_AT; i++) r = crc_shift_byte(r, body[i], cfg_poly);
    body[CRC_AT]     = r[15:8];
    body[CRC_AT + 1] = r[7:0];
    if (!good_crc) begin
      flip = CRC_AT + $urandom_range(1);
      body[flip] = body[flip] ^ (8'd1 << $urandom_range(7));
    end
  endtask

  // frame bytes lo .. hi-1, bit by bit
  task automatic send_bytes(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      for (int k = 7; k >= 0; k--) begin
        // gaps inside the frame are ignored by the block
        if (i >= 4 && $urandom_range(99) < 2) send_item(ACT_GAP, 1'($urandom_range(1)));
        send_item(ACT_BIT, body[i][k] ^ cfg_inv);
      end
    end
  endtask

  // stop offering and let every expected byte leave
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // finish any frame that is still open, then let everything drain
  task automatic settle();
    while (framing) send_item(ACT_BIT, 1'($urandom_range(1)));
    drain();
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic inv, input logic [31:0] sw, input logic [15:0] poly,
                            input logic [15:0] seed);
    logic [swfd_pkg::CFG_IDX_W-1:0] regs [4];
    logic [31:0]                    vals [4];
    regs[0] = swfd_pkg::REG_INVERT;    vals[0] = {31'd0, inv};
    regs[1] = swfd_pkg::REG_SYNC_WORD; vals[1] = sw;
    regs[2] = swfd_pkg::REG_CRC_POLY;  vals[2] = {16'd0, poly};
    regs[3] = swfd_pkg::REG_CRC_SEED;  vals[3] = {16'd0, seed};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (regs[i])
        swfd_pkg::REG_INVERT:    cfg_inv  = vals[i][0];
        swfd_pkg::REG_SYNC_WORD: cfg_sync = vals[i];
        swfd_pkg::REG_CRC_POLY:  cfg_poly = vals[i][15:0];
        swfd_pkg::REG_CRC_SEED:  cfg_seed = vals[i][15:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // compare each output transfer with the oldest expected byte
  always @(posedge clk) begin : check_out
    frame_byte_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte_value, out_byte_index, out_last, out_crc_ok};
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected byte %02h pos %0d last %0b crc_ok %0b", got.value, got.pos,
                   got.last, got.crc_ok);
      end else begin
        want = expected_bytes.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %02h/%0d/%0b/%0b got %02h/%0d/%0b/%0b", want.value,
                     want.pos, want.last, want.crc_ok, got.value, got.pos, got.last,
                     got.crc_ok);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    // gaps with either bit value, then the reset sync word locks at once
    directed[0] = '{ACT_GAP, 32'd0, 1, 0};
    directed[1] = '{ACT_GAP, 32'd1, 1, 0};
    directed[2] = '{ACT_BIT, swfd_pkg::SYNC_WORD_RST, 32, 4};
    typed_bytes.push_back('{8'h55, 6'd0, 1'b0, 1'b0});
    typed_bytes.push_back('{8'h55, 6'd1, 1'b0, 1'b0});
    typed_bytes.push_back('{8'h55, 6'd2, 1'b0, 1'b0});
    typed_bytes.push_back('{8'h2D, 6'd3, 1'b0, 1'b0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    use_typed = 1'b1;
    foreach (directed[r]) begin
      repeat (directed[r].nres) expected_bytes.push_back(typed_bytes.pop_front());
      for (int k = directed[r].nbits - 1; k >= 0; k--)
        send_item(directed[r].act, directed[r].pattern[k]);
    end
    use_typed = 1'b0;

    // the directed sync left a frame open: its payload is spread over the phases
    make_frame(1'b1);
    for (int p = 0; p < 4; p++) begin
      case (p)
        1: begin
          // inversion changes mid-frame; sync word and seed only matter at the next sync
          drain();
          set_config(1'b1, 32'hFFFF_FFFF, cfg_poly, 16'hFFFF);
          snd_idle_pct = 76;
          rcv_stall_pct = 0;
        end
        2: begin
          drain();
          set_config(1'b0, 32'h0000_0000, cfg_poly, 16'h0000);
          snd_idle_pct = 0;
          rcv_stall_pct = 76;
        end
        3: begin
          drain();
          set_config(1'b1, 32'($urandom), cfg_poly, 16'($urandom));
          snd_idle_pct = 25;
          rcv_stall_pct = 25;
          hold_req = 1'b1;
        end
        default: ;
      endcase
      send_bytes(4 + PHASE_BYTES * p, 4 + PHASE_BYTES * (p + 1));
    end

    // back to hunting under a fresh setup
    settle();
    set_config(1'($urandom_range(1)), 32'($urandom), 16'($urandom), 16'($urandom));
    send_broken_sync();

    settle();
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
